// ===== rtl/core/mi4_pkg.sv =====
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants for the 4x4 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

  // Default element format: signed Q16.16.
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

endpackage

// ===== rtl/core/matrix4_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix4_inverse
// Inverse of a 4x4 signed fixed-point matrix through the adjugate, built on a
// single shared add/subtract unit driven by a small sequencer.
// ----------------------------------------------------------------------------
// Operation: the sixteen elements are loaded, the cofactors and the determinant
// are formed by bit-serial multiplies, |det| is taken, then each result comes
// from a restoring division (singular: zero results, no division).
// One matrix is handled at a time (Q16.16 by default); the input
// is stalled from the sixteenth element until the last result is taken.
// Reset (rst_ni, async, active low) clears sequencer and count; stores hold no reset.
module matrix4_inverse
  import mi4_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] element_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] inverse_value_o,
  output logic                         singular_o,
  output logic                         saturated_o,
  output logic                         last_o
);

  // Accumulator width: the determinant is a sum of 24 four-way products of
  // DATA_WIDTH-bit values and fits in 4*DATA_WIDTH+4 bits with room to spare.
  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned AW  = 4 * W + 4;
  localparam int unsigned QW  = W + 1;
  // Division steps: the magnitude of the cofactor, then 2*FRAC_BITS+1 zero
  // bits that scale the quotient and leave one bit for rounding.
  localparam int unsigned NI  = AW + 2 * FRAC_BITS + 1;
  localparam int unsigned BW  = $clog2(W);
  localparam int unsigned IW  = $clog2(NI);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH_X,
    ST_FETCH_Y,
    ST_MUL,
    ST_NEXT,
    ST_DABS,
    ST_ABS,
    ST_DIV,
    ST_ROUND,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    TGT_MINOR,
    TGT_COF,
    TGT_DET
  } target_e;

  // Element store and cofactor store. Each is read through a single mux.
  logic signed [W-1:0]  store_q [16];
  logic signed [AW-1:0] cof_arr_q [16];

  state_e          state_q;
  logic [4:0]      cnt_q;          // elements loaded so far
  logic [3:0]      k_q;            // cofactor, determinant term or result index
  logic [1:0]      t_q;            // expansion term of a cofactor
  logic [1:0]      p_q;            // product within a term
  logic            det_phase_q;
  logic            sing_q;

  logic [W-1:0]    x_q;            // multiplier, consumed one bit a cycle
  logic [AW-1:0]   bsh_q;          // multiplicand, shifted one place a cycle
  logic [BW-1:0]   bit_q;
  logic [AW-1:0]   minor_q;
  logic [AW-1:0]   cof_q;
  logic [AW-1:0]   det_q;

  logic [AW-1:0]   dabs_q;
  logic            dneg_q;
  logic            cneg_q;
  logic [AW-1:0]   num_q;
  logic [AW-1:0]   rem_q;
  logic [QW-1:0]   q_q;
  logic            ovf_q;
  logic [IW-1:0]   it_q;

  logic signed [W-1:0] value_q;
  logic            valid_q;
  logic            singular_q;
  logic            saturated_q;
  logic            last_q;

  // Columns other than c, in ascending order.
  function automatic logic [1:0] other_col(input logic [1:0] c, input logic [1:0] n);
    other_col = (n < c) ? n : n + 2'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Operand addressing for the cofactor expansion. For cofactor (r,c) the
  // first remaining row multiplies the 2x2 minors taken from the other two.
  // ---------------------------------------------------------------------------
  logic [1:0] r_s, c_s, rr0, rr1, rr2, tp1, tp2, c1, c2, ce;
  logic [3:0] x_idx, y_idx, rd_addr, cof_addr;
  logic signed [W-1:0]  rd_elem;
  logic signed [AW-1:0] cof_rd;
  logic [AW-1:0] y_val;
  target_e       tgt;
  logic [AW-1:0] tgt_val;
  logic          neg_op, mul_sub;

  always_comb begin
    r_s = k_q[3:2];
    c_s = k_q[1:0];
    rr0 = (r_s == 2'd0) ? 2'd1 : 2'd0;
    rr1 = (r_s < 2'd2) ? 2'd2 : 2'd1;
    rr2 = (r_s == 2'd3) ? 2'd2 : 2'd3;
    tp1 = (t_q == 2'd0) ? 2'd1 : ((t_q == 2'd1) ? 2'd2 : 2'd0);
    tp2 = (t_q == 2'd0) ? 2'd2 : ((t_q == 2'd1) ? 2'd0 : 2'd1);
    c1  = other_col(c_s, tp1);
    c2  = other_col(c_s, tp2);
    ce  = other_col(c_s, t_q);

    if (det_phase_q) begin
      x_idx = {2'd0, k_q[1:0]};
    end else if (p_q == 2'd0) begin
      x_idx = {rr1, c1};
    end else if (p_q == 2'd1) begin
      x_idx = {rr1, c2};
    end else begin
      x_idx = {rr0, ce};
    end
    y_idx   = (p_q == 2'd0) ? {rr2, c2} : {rr2, c1};
    rd_addr = (state_q == ST_FETCH_X) ? x_idx : y_idx;
    rd_elem = store_q[rd_addr];

    // Determinant terms read row 0 cofactors; results read transposed.
    cof_addr = det_phase_q ? {2'd0, k_q[1:0]} : {k_q[1:0], k_q[3:2]};
    cof_rd   = cof_arr_q[cof_addr];

    if (det_phase_q) begin
      y_val = cof_rd;
    end else if (p_q == 2'd2) begin
      y_val = minor_q;
    end else begin
      y_val = {{(AW-W){rd_elem[W-1]}}, rd_elem};
    end

    if (det_phase_q) begin
      tgt = TGT_DET;
    end else if (p_q == 2'd2) begin
      tgt = TGT_COF;
    end else begin
      tgt = TGT_MINOR;
    end
    unique case (tgt)
      TGT_DET: tgt_val = det_q;
      TGT_COF: tgt_val = cof_q;
      default: tgt_val = minor_q;
    endcase

    // The second product of a minor is subtracted, and odd cofactor
    // positions carry a negative sign. The multiplier's top bit weighs
    // negative in two's complement, which flips the operation once more.
    neg_op  = !det_phase_q && ((p_q == 2'd1) || ((p_q == 2'd2) && (r_s[0] ^ c_s[0])));
    mul_sub = (bit_q == BW'(W - 1)) ^ neg_op;
  end

  // ---------------------------------------------------------------------------
  // The shared add/subtract unit: multiply steps, absolute values and the
  // trial subtraction of the divider all go through it.
  // ---------------------------------------------------------------------------
  logic [AW:0] opa, opb, sum;
  logic        sub;
  logic [AW:0] remsh;

  always_comb begin
    remsh = {rem_q, num_q[AW-1]};
    unique case (state_q)
      ST_DABS: begin
        opa = '0;
        opb = {det_q[AW-1], det_q};
        sub = 1'b1;
      end
      ST_ABS: begin
        opa = '0;
        opb = {cof_rd[AW-1], cof_rd};
        sub = 1'b1;
      end
      ST_DIV: begin
        opa = remsh;
        opb = {1'b0, dabs_q};
        sub = 1'b1;
      end
      default: begin
        opa = {tgt_val[AW-1], tgt_val};
        opb = {bsh_q[AW-1], bsh_q};
        sub = mul_sub;
      end
    endcase
    sum = opa + (opb ^ {(AW+1){sub}}) + {{AW{1'b0}}, sub};
  end

  // Rounding and saturation of one quotient.
  logic [W+1:0]  qinc;
  logic [QW-1:0] qr, lim;
  logic          rneg, rsat;
  logic [W-1:0]  rval;

  always_comb begin
    qinc = {1'b0, q_q} + {{(W+1){1'b0}}, 1'b1};
    qr   = qinc[W+1:1];
    rneg = (cneg_q ^ dneg_q) && (ovf_q || (qr != '0));
    lim  = rneg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    rsat = ovf_q || (qr > lim);
    if (rsat) begin
      rval = rneg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (rneg) begin
      rval = -qr[W-1:0];
    end else begin
      rval = qr[W-1:0];
    end
  end

  // Stores are payload only and take no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && in_valid_i) begin
      store_q[cnt_q[3:0]] <= element_value_i;
    end
    if (state_q == ST_NEXT && !det_phase_q && p_q == 2'd2 && t_q == 2'd2) begin
      cof_arr_q[k_q] <= cof_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      t_q         <= '0;
      p_q         <= '0;
      det_phase_q <= 1'b0;
      sing_q      <= 1'b0;
      x_q         <= '0;
      bsh_q       <= '0;
      bit_q       <= '0;
      minor_q     <= '0;
      cof_q       <= '0;
      det_q       <= '0;
      dabs_q      <= '0;
      dneg_q      <= 1'b0;
      cneg_q      <= 1'b0;
      num_q       <= '0;
      rem_q       <= '0;
      q_q         <= '0;
      ovf_q       <= 1'b0;
      it_q        <= '0;
      value_q     <= '0;
      valid_q     <= 1'b0;
      singular_q  <= 1'b0;
      saturated_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_valid_i) begin
            if (cnt_q == 5'd15) begin
              cnt_q       <= '0;
              k_q         <= '0;
              t_q         <= '0;
              p_q         <= '0;
              det_phase_q <= 1'b0;
              state_q     <= ST_FETCH_X;
            end else begin
              cnt_q <= cnt_q + 5'd1;
            end
          end
        end

        ST_FETCH_X: begin
          x_q <= rd_elem;
          if (det_phase_q) begin
            if (k_q == 4'd0) begin
              det_q <= '0;
            end
          end else if (p_q == 2'd0) begin
            minor_q <= '0;
          end else if (p_q == 2'd2 && t_q == 2'd0) begin
            cof_q <= '0;
          end
          state_q <= ST_FETCH_Y;
        end

        ST_FETCH_Y: begin
          bsh_q   <= y_val;
          bit_q   <= '0;
          state_q <= ST_MUL;
        end

        ST_MUL: begin
          if (x_q[0]) begin
            unique case (tgt)
              TGT_DET: det_q   <= sum[AW-1:0];
              TGT_COF: cof_q   <= sum[AW-1:0];
              default: minor_q <= sum[AW-1:0];
            endcase
          end
          x_q   <= x_q >> 1;
          bsh_q <= bsh_q << 1;
          bit_q <= bit_q + BW'(1);
          if (bit_q == BW'(W - 1)) begin
            state_q <= ST_NEXT;
          end
        end

        ST_NEXT: begin
          if (det_phase_q) begin
            if (k_q == 4'd3) begin
              k_q <= '0;
              if (det_q == '0) begin
                // Singular matrix: zeros with the flag, no division.
                sing_q      <= 1'b1;
                value_q     <= '0;
                singular_q  <= 1'b1;
                saturated_q <= 1'b0;
                last_q      <= 1'b0;
                valid_q     <= 1'b1;
                det_phase_q <= 1'b0;
                state_q     <= ST_EMIT;
              end else begin
                state_q <= ST_DABS;
              end
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= ST_FETCH_X;
            end
          end else if (p_q != 2'd2) begin
            p_q     <= p_q + 2'd1;
            state_q <= ST_FETCH_X;
          end else begin
            p_q <= '0;
            if (t_q != 2'd2) begin
              t_q <= t_q + 2'd1;
            end else begin
              t_q <= '0;
              if (k_q == 4'd15) begin
                det_phase_q <= 1'b1;
                k_q         <= '0;
              end else begin
                k_q <= k_q + 4'd1;
              end
            end
            state_q <= ST_FETCH_X;
          end
        end

        ST_DABS: begin
          dneg_q      <= det_q[AW-1];
          dabs_q      <= det_q[AW-1] ? sum[AW-1:0] : det_q;
          det_phase_q <= 1'b0;
          k_q         <= '0;
          state_q     <= ST_ABS;
        end

        ST_ABS: begin
          cneg_q  <= cof_rd[AW-1];
          num_q   <= cof_rd[AW-1] ? sum[AW-1:0] : cof_rd;
          rem_q   <= '0;
          q_q     <= '0;
          ovf_q   <= 1'b0;
          it_q    <= '0;
          state_q <= ST_DIV;
        end

        ST_DIV: begin
          // Restoring division, one quotient bit a cycle. Quotient bits that
          // leave the top only matter as an overflow mark.
          num_q <= num_q << 1;
          if (!sum[AW]) begin
            rem_q <= sum[AW-1:0];
          end else begin
            rem_q <= remsh[AW-1:0];
          end
          ovf_q <= ovf_q | q_q[QW-1];
          q_q   <= {q_q[QW-2:0], !sum[AW]};
          it_q  <= it_q + IW'(1);
          if (it_q == IW'(NI - 1)) begin
            state_q <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          value_q     <= rval;
          singular_q  <= 1'b0;
          saturated_q <= rsat;
          last_q      <= (k_q == 4'd15);
          valid_q     <= 1'b1;
          state_q     <= ST_EMIT;
        end

        ST_EMIT: begin
          if (!out_stall_i) begin
            if (k_q == 4'd15) begin
              valid_q <= 1'b0;
              sing_q  <= 1'b0;
              k_q     <= '0;
              state_q <= ST_LOAD;
            end else begin
              k_q <= k_q + 4'd1;
              if (sing_q) begin
                value_q <= '0;
                last_q  <= (k_q == 4'd14);
              end else begin
                valid_q <= 1'b0;
                state_q <= ST_ABS;
              end
            end
          end
        end

        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign in_stall_o      = (state_q != ST_LOAD);
  assign out_valid_o     = valid_q;
  assign inverse_value_o = value_q;
  assign singular_o      = singular_q;
  assign saturated_o     = saturated_q;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  // Elements are never taken while a result is on offer.
  a_no_load_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // Taking the last result reopens the input.
  a_reopen_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !in_stall_o && !out_valid_o)
    else $error("input not reopened after the last result");

  // A singular result is zero and never clipped.
  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> (inverse_value_o == '0) && !saturated_o)
    else $error("singular result carries a value");

  // The element count stays within one matrix.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 5'd16)
    else $error("element count out of range");
`endif

endmodule
